// ===== sv/beh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binned efficiency histogrammer package
// Shared request and result types, bin edge tables, control types.
// ----------------------------------------------------------------------------
package beh_pkg;

    // Default configuration.
    localparam int DEF_PT_BINS    = 15;
    localparam int DEF_ETA_BINS   = 16;
    localparam int DEF_PHI_BINS   = 12;
    localparam int DEF_COUNT_BITS = 32;

    // Number of entries held in each edge table.
    localparam int EDGE_SLOTS = 32;
    // Width of the signed value used for bin compares.
    localparam int VAL_W      = 18;
    // Number of fractional quotient bits of an efficiency.
    localparam int FRAC_BITS  = 16;

    typedef logic signed [VAL_W-1:0] t_edge_tab [EDGE_SLOTS];

    // Edge tables: ceil(edge * scale), trailing entries repeat the last edge.
    localparam t_edge_tab PT_EDGES = '{
        320, 384, 448, 512, 576, 640, 768, 896, 1024, 1152, 1280, 1600, 1920, 2240,
        2560, 3200, 3200, 3200, 3200, 3200, 3200, 3200, 3200, 3200, 3200, 3200, 3200,
        3200, 3200, 3200, 3200, 3200};
    localparam t_edge_tab ETA_EDGES = '{
        0, 820, 1639, 2458, 3277, 4096, 4916, 5916, 6415, 7373, 8192, 8602, 9012, 9421,
        9831, 10240, 10650, 10650, 10650, 10650, 10650, 10650, 10650, 10650, 10650,
        10650, 10650, 10650, 10650, 10650, 10650, 10650};
    localparam t_edge_tab PHI_EDGES = '{
        -13107, -10240, -8192, -6144, -4096, -2048, 0, 2048, 4096, 6144, 8192, 10240,
        13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108,
        13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108, 13108};

    // Operation codes.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [15:0]        pt;
        logic signed [15:0] eta;
        logic signed [15:0] phi;
        logic               passed;
        logic               reco_found;
        logic [4:0]         read_pt_bin;
        logic [4:0]         read_eta_bin;
        logic [3:0]         read_phi_bin;
    } t_in_req;

    typedef struct packed {
        logic [4:0]  pt_index;
        logic [4:0]  eta_index;
        logic [3:0]  phi_index;
        logic [31:0] pass_count_3d;
        logic [31:0] total_count_3d;
        logic [16:0] efficiency_3d;
        logic [31:0] pass_count_2d;
        logic [31:0] total_count_2d;
        logic [16:0] efficiency_2d;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_MIX,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr;
        logic load;
        logic bin;
        logic mix;
        logic addr;
        logic upd;
        logic div;
        logic fin;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic div_last;
    } t_dp_sts;

    // Bin of a value: the number of edges 0..n at or below it. The edges
    // never fall, so this matches the first interval that holds the value.
    function automatic logic [5:0] bin_count(
        input logic signed [VAL_W-1:0] v,
        input t_edge_tab               tab,
        input int                      n
    );
        logic [5:0] c;
        c = '0;
        for (int k = 0; k < EDGE_SLOTS; k++) begin
            if (k <= n && v >= tab[k]) begin
                c = c + 6'd1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/binned_efficiency_histogrammer.sv =====
`timescale 1ns / 1ps
// A request passes the states BIN, MIX, ADDR, READ, UPDATE, DIV and FIN before
// its result is offered in OUT. One request at a time: a new one is taken only
// in IDLE, after the result is accepted; DIV runs the 16-step shift-subtract divider.
// Reset: after reset a clearing pass zeroes the counter memories, one entry
// per cycle, before the first request is taken.
// ----------------------------------------------------------------------------
// Binned efficiency histogrammer
// Bins events on pt, |eta| and phi, counts them in 3D and 2D histograms and
// returns the bin counts with pass over total efficiencies.
// ----------------------------------------------------------------------------
module binned_efficiency_histogrammer #(
    parameter int PT_BINS    = beh_pkg::DEF_PT_BINS,
    parameter int ETA_BINS   = beh_pkg::DEF_ETA_BINS,
    parameter int PHI_BINS   = beh_pkg::DEF_PHI_BINS,
    parameter int COUNT_BITS = beh_pkg::DEF_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  beh_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output beh_pkg::t_out_req o_out_req
);

    beh_pkg::t_dp_cmd w_cmd;
    beh_pkg::t_dp_sts w_sts;

    // Sequencer.
    beh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath with the counter memories.
    beh_dp #(
        .PT_BINS    (PT_BINS),
        .ETA_BINS   (ETA_BINS),
        .PHI_BINS   (PHI_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_req  (i_in_req),
        .o_out_req (o_out_req),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts)
    );

endmodule

// ===== sv/beh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module beh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/beh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogrammer controller
// Sequences the clearing pass, the binning, the counter update, the division and the output handshake.
// ----------------------------------------------------------------------------
module beh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output beh_pkg::t_dp_cmd o_cmd,
    input  beh_pkg::t_dp_sts i_sts
);

    beh_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= beh_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            beh_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = beh_pkg::ST_IDLE;
                end
            end
            beh_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = beh_pkg::ST_BIN;
                end
            end
            beh_pkg::ST_BIN: begin
                o_cmd.bin = 1'b1;
                n_state   = beh_pkg::ST_MIX;
            end
            beh_pkg::ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = beh_pkg::ST_ADDR;
            end
            beh_pkg::ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = beh_pkg::ST_READ;
            end
            beh_pkg::ST_READ: begin
                n_state = beh_pkg::ST_UPDATE;
            end
            beh_pkg::ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = beh_pkg::ST_DIV;
            end
            beh_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = beh_pkg::ST_FIN;
                end
            end
            beh_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = beh_pkg::ST_OUT;
            end
            beh_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = beh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = beh_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/beh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogrammer datapath
// Binning, bin address, counter memories, saturating update and dividers.
// ----------------------------------------------------------------------------
module beh_dp #(
    parameter int PT_BINS    = beh_pkg::DEF_PT_BINS,
    parameter int ETA_BINS   = beh_pkg::DEF_ETA_BINS,
    parameter int PHI_BINS   = beh_pkg::DEF_PHI_BINS,
    parameter int COUNT_BITS = beh_pkg::DEF_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  beh_pkg::t_in_req i_in_req,
    output beh_pkg::t_out_req o_out_req,
    input  beh_pkg::t_dp_cmd i_cmd,
    output beh_pkg::t_dp_sts o_sts
);

    localparam int NPT  = PT_BINS + 2;
    localparam int NETA = ETA_BINS + 2;
    localparam int NPHI = PHI_BINS + 2;
    localparam int PW   = $clog2(NPT);
    localparam int EW   = $clog2(NETA);
    localparam int HW   = $clog2(NPHI);
    localparam int D2   = NPT * NETA;
    localparam int D3   = D2 * NPHI;
    localparam int A2   = $clog2(D2);
    localparam int A3   = $clog2(D3);
    localparam int CW   = COUNT_BITS;
    localparam int FB   = beh_pkg::FRAC_BITS;
    localparam int VW   = beh_pkg::VAL_W;
    localparam int SW   = $clog2(FB);

    beh_pkg::t_in_req r_req;
    logic [PW-1:0]    r_pb;
    logic [EW-1:0]    r_eb;
    logic [HW-1:0]    r_hb;
    logic [A2-1:0]    r_i2;
    logic [A3-1:0]    r_i3;
    logic [A3-1:0]    r_clr;
    logic [CW-1:0]    r_p3, r_t3, r_p2, r_t2;
    logic [CW:0]      r_rem3, r_rem2;
    logic [FB-1:0]    r_q3, r_q2;
    logic [SW-1:0]    r_step;
    beh_pkg::t_out_req r_out;

    logic [2*CW-1:0] w_rd3, w_rd2;
    logic [CW-1:0]   n_p3, n_t3, n_p2, n_t2;
    logic            w_rec, w_hit;
    logic [CW:0]     w_sh3, w_sh2;
    logic            w_b3, w_b2;
    logic signed [VW-1:0] w_pt, w_eta, w_phi;
    logic [5:0]      w_pb, w_eb, w_hb;
    logic            w_we3, w_we2;
    logic [A3-1:0]   w_wa3;
    logic [A2-1:0]   w_wa2;
    logic [2*CW-1:0] w_wd3, w_wd2;
    logic [16:0]     w_eff3, w_eff2;

    // Bin values of a recorded event, or the clamped bins of a read.
    always_comb begin
        w_pt  = VW'(r_req.pt);
        w_eta = VW'(r_req.eta);
        w_phi = VW'(r_req.phi);
        if (w_eta < 0) begin
            w_eta = -w_eta;
        end
        if (r_req.op == beh_pkg::OP_READ) begin
            w_pb = (6'(r_req.read_pt_bin) > 6'(PT_BINS + 1)) ?
                   6'(PT_BINS + 1) : 6'(r_req.read_pt_bin);
            w_eb = (6'(r_req.read_eta_bin) > 6'(ETA_BINS + 1)) ?
                   6'(ETA_BINS + 1) : 6'(r_req.read_eta_bin);
            w_hb = (6'(r_req.read_phi_bin) > 6'(PHI_BINS + 1)) ?
                   6'(PHI_BINS + 1) : 6'(r_req.read_phi_bin);
        end else begin
            w_pb = beh_pkg::bin_count(w_pt, beh_pkg::PT_EDGES, PT_BINS);
            w_eb = beh_pkg::bin_count(w_eta, beh_pkg::ETA_EDGES, ETA_BINS);
            w_hb = beh_pkg::bin_count(w_phi, beh_pkg::PHI_EDGES, PHI_BINS);
        end
    end

    // Saturating counter update from the memory words.
    always_comb begin
        w_rec = (r_req.op == beh_pkg::OP_RECORD);
        w_hit = w_rec && r_req.passed && r_req.reco_found;
        n_p3  = w_rd3[2*CW-1:CW];
        n_t3  = w_rd3[CW-1:0];
        n_p2  = w_rd2[2*CW-1:CW];
        n_t2  = w_rd2[CW-1:0];
        if (w_rec) begin
            n_t3 = (&n_t3) ? n_t3 : n_t3 + CW'(1);
            n_t2 = (&n_t2) ? n_t2 : n_t2 + CW'(1);
        end
        if (w_hit) begin
            n_p3 = (&n_p3) ? n_p3 : n_p3 + CW'(1);
            n_p2 = (&n_p2) ? n_p2 : n_p2 + CW'(1);
        end
    end

    // One quotient bit per cycle for each divider.
    always_comb begin
        w_sh3 = {r_rem3[CW-1:0], 1'b0};
        w_sh2 = {r_rem2[CW-1:0], 1'b0};
        w_b3  = (w_sh3 >= {1'b0, r_t3});
        w_b2  = (w_sh2 >= {1'b0, r_t2});
    end

    // Memory write port: clearing pass or counter write-back.
    always_comb begin
        if (i_cmd.clr) begin
            w_we3 = 1'b1;
            w_we2 = (32'(r_clr) < D2);
            w_wa3 = r_clr;
            w_wa2 = r_clr[A2-1:0];
            w_wd3 = '0;
            w_wd2 = '0;
        end else begin
            w_we3 = i_cmd.upd && w_rec;
            w_we2 = i_cmd.upd && w_rec;
            w_wa3 = r_i3;
            w_wa2 = r_i2;
            w_wd3 = {n_p3, n_t3};
            w_wd2 = {n_p2, n_t2};
        end
    end

    // Efficiencies with the empty and full special cases.
    always_comb begin
        if (r_t3 == '0) begin
            w_eff3 = '0;
        end else if (r_p3 == r_t3) begin
            w_eff3 = 17'h10000;
        end else begin
            w_eff3 = {1'b0, r_q3};
        end
        if (r_t2 == '0) begin
            w_eff2 = '0;
        end else if (r_p2 == r_t2) begin
            w_eff2 = 17'h10000;
        end else begin
            w_eff2 = {1'b0, r_q2};
        end
    end

    beh_ram #(.WIDTH(2 * CW), .DEPTH(D3)) u_ram3 (
        .i_clk   (i_clk),
        .i_we    (w_we3),
        .i_waddr (w_wa3),
        .i_wdata (w_wd3),
        .i_raddr (r_i3),
        .o_rdata (w_rd3)
    );

    beh_ram #(.WIDTH(2 * CW), .DEPTH(D2)) u_ram2 (
        .i_clk   (i_clk),
        .i_we    (w_we2),
        .i_waddr (w_wa2),
        .i_wdata (w_wd2),
        .i_raddr (r_i2),
        .o_rdata (w_rd2)
    );

    // Clearing pass address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + A3'(1);
        end
    end

    // Division step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div) begin
            r_step <= r_step + SW'(1);
        end
    end

    assign o_sts.clr_last = (32'(r_clr) == D3 - 1);
    assign o_sts.div_last = (&r_step);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_req;
        end
        if (i_cmd.bin) begin
            r_pb <= PW'(w_pb);
            r_eb <= EW'(w_eb);
            r_hb <= HW'(w_hb);
        end
        if (i_cmd.mix) begin
            r_i2 <= A2'(int'(r_pb) * NETA + int'(r_eb));
        end
        if (i_cmd.addr) begin
            r_i3 <= A3'(int'(r_i2) * NPHI + int'(r_hb));
        end
        if (i_cmd.upd) begin
            r_p3   <= n_p3;
            r_t3   <= n_t3;
            r_p2   <= n_p2;
            r_t2   <= n_t2;
            r_rem3 <= {1'b0, n_p3};
            r_rem2 <= {1'b0, n_p2};
            r_q3   <= '0;
            r_q2   <= '0;
        end
        if (i_cmd.div) begin
            r_rem3 <= w_b3 ? w_sh3 - {1'b0, r_t3} : w_sh3;
            r_rem2 <= w_b2 ? w_sh2 - {1'b0, r_t2} : w_sh2;
            r_q3   <= {r_q3[FB-2:0], w_b3};
            r_q2   <= {r_q2[FB-2:0], w_b2};
        end
        if (i_cmd.fin) begin
            r_out.pt_index       <= 5'(r_pb);
            r_out.eta_index      <= 5'(r_eb);
            r_out.phi_index      <= 4'(r_hb);
            r_out.pass_count_3d  <= 32'(r_p3);
            r_out.total_count_3d <= 32'(r_t3);
            r_out.efficiency_3d  <= w_eff3;
            r_out.pass_count_2d  <= 32'(r_p2);
            r_out.total_count_2d <= 32'(r_t2);
            r_out.efficiency_2d  <= w_eff2;
        end
    end

    assign o_out_req = r_out;

endmodule

// ===== test/binned_efficiency_histogrammer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binned efficiency histogrammer checker
// Watches both channels, keeps its own copy of the histogram counters,
// predicts each result from the accepted request and compares the whole
// result with the block's output.
// ----------------------------------------------------------------------------
module binned_efficiency_histogrammer_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  beh_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  beh_pkg::t_out_req i_out_req,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);

    localparam int NPT  = beh_pkg::DEF_PT_BINS + 2;
    localparam int NETA = beh_pkg::DEF_ETA_BINS + 2;
    localparam int NPHI = beh_pkg::DEF_PHI_BINS + 2;
    localparam longint CMAX = (64'd1 << beh_pkg::DEF_COUNT_BITS) - 1;

    longint unsigned pass3 [NPT*NETA*NPHI];
    longint unsigned tot3  [NPT*NETA*NPHI];
    longint unsigned pass2 [NPT*NETA];
    longint unsigned tot2  [NPT*NETA];
    beh_pkg::t_out_req expected_results [$];

    // Bin of a value against the first n+1 entries of an ascending edge table.
    function automatic int axis_bin(input int v, input beh_pkg::t_edge_tab tab,
                                    input int n);
        int b;
        b = 0;
        for (int k = 0; k < n; k++) begin
            if (v >= int'(tab[k]) && v < int'(tab[k+1])) b = k + 1;
        end
        if (v >= int'(tab[n])) b = n + 1;
        return b;
    endfunction

    function automatic longint unsigned bump(input longint unsigned c);
        return (c >= CMAX) ? CMAX : c + 1;
    endfunction

    function automatic logic [16:0] efficiency(input longint unsigned p,
                                                input longint unsigned t);
        longint unsigned q;
        if (t == 0) return '0;
        q = (p << 16) / t;
        return (q > 65536) ? 17'd65536 : q[16:0];
    endfunction

    // Update the counters for one request and build the result it yields.
    function automatic beh_pkg::t_out_req histogram_update(input beh_pkg::t_in_req r);
        int pb, eb, hb, i2, i3, e;
        beh_pkg::t_out_req o;
        if (r.op == beh_pkg::OP_READ) begin
            pb = (int'(r.read_pt_bin) > NPT-1) ? NPT-1 : int'(r.read_pt_bin);
            eb = (int'(r.read_eta_bin) > NETA-1) ? NETA-1 : int'(r.read_eta_bin);
            hb = (int'(r.read_phi_bin) > NPHI-1) ? NPHI-1 : int'(r.read_phi_bin);
        end else begin
            e  = int'(r.eta);
            if (e < 0) e = -e;
            pb = axis_bin(int'({1'b0, r.pt}), beh_pkg::PT_EDGES, beh_pkg::DEF_PT_BINS);
            eb = axis_bin(e, beh_pkg::ETA_EDGES, beh_pkg::DEF_ETA_BINS);
            hb = axis_bin(int'(r.phi), beh_pkg::PHI_EDGES, beh_pkg::DEF_PHI_BINS);
        end
        i2 = pb * NETA + eb;
        i3 = i2 * NPHI + hb;
        if (r.op == beh_pkg::OP_RECORD) begin
            tot3[i3] = bump(tot3[i3]);
            tot2[i2] = bump(tot2[i2]);
            if (r.passed && r.reco_found) begin
                pass3[i3] = bump(pass3[i3]);
                pass2[i2] = bump(pass2[i2]);
            end
        end
        o.pt_index       = pb[4:0];
        o.eta_index      = eb[4:0];
        o.phi_index      = hb[3:0];
        o.pass_count_3d  = pass3[i3][31:0];
        o.total_count_3d = tot3[i3][31:0];
        o.efficiency_3d  = efficiency(pass3[i3], tot3[i3]);
        o.pass_count_2d  = pass2[i2][31:0];
        o.total_count_2d = tot2[i2][31:0];
        o.efficiency_2d  = efficiency(pass2[i2], tot2[i2]);
        return o;
    endfunction

    assign o_pending = expected_results.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        beh_pkg::t_out_req want;
        if (!i_rst_n) begin
            foreach (pass3[k]) begin
                pass3[k] = 0;
                tot3[k]  = 0;
            end
            foreach (pass2[k]) begin
                pass2[k] = 0;
                tot2[k]  = 0;
            end
            expected_results.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(histogram_update(i_in_req));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_req);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_req) begin
                        $display("%0t: result differs: expected %p, actual %p",
                                 $time, want, i_out_req);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== test/binned_efficiency_histogrammer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binned efficiency histogrammer testbench
// Drives directed and random record and read requests with random idling on
// both channels; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module binned_efficiency_histogrammer_tb;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    beh_pkg::t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    beh_pkg::t_out_req out_req;
    int       errors, pending, results;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       records = 0, reads = 0;

    always #5 i_clk = ~i_clk;

    binned_efficiency_histogrammer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_req(in_req),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_req(out_req)
    );

    binned_efficiency_histogrammer_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_req(in_req),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_req(out_req),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver stall, redrawn every cycle.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Hand one request to the block and hold it until accepted. Valid stays
    // high after acceptance so that requests can follow back to back.
    task automatic send_request(input beh_pkg::t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (r.op == beh_pkg::OP_READ) reads++;
        else records++;
    endtask

    function automatic beh_pkg::t_in_req event_request(input logic [15:0] pt,
                                                       input logic [15:0] eta,
                                                       input logic [15:0] phi,
                                                       input logic ps, input logic rf);
        beh_pkg::t_in_req r;
        r = '0;
        r.op = beh_pkg::OP_RECORD;
        r.pt = pt;
        r.eta = eta;
        r.phi = phi;
        r.passed = ps;
        r.reco_found = rf;
        r.read_pt_bin = 5'($urandom);
        r.read_eta_bin = 5'($urandom);
        r.read_phi_bin = 4'($urandom);
        return r;
    endfunction

    function automatic beh_pkg::t_in_req read_request(input logic [4:0] pb,
                                                      input logic [4:0] eb,
                                                      input logic [3:0] hb);
        beh_pkg::t_in_req r;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(beh_pkg::t_in_req)-1:0];
        r.op = beh_pkg::OP_READ;
        r.read_pt_bin = pb;
        r.read_eta_bin = eb;
        r.read_phi_bin = hb;
        return r;
    endfunction

    // Random request: mostly events near the edge tables, some raw noise, some reads.
    function automatic beh_pkg::t_in_req random_request();
        int k;
        logic [15:0] pt, eta, phi;
        k = $urandom_range(99);
        if (k < 20) return read_request(5'($urandom), 5'($urandom), 4'($urandom));
        if (k < 35) return event_request(16'($urandom), 16'($urandom), 16'($urandom),
                                         1'($urandom), 1'($urandom));
        pt  = 16'(beh_pkg::PT_EDGES[$urandom_range(beh_pkg::DEF_PT_BINS)]
                  + $urandom_range(4) - 2);
        eta = 16'(beh_pkg::ETA_EDGES[$urandom_range(beh_pkg::DEF_ETA_BINS)]
                  + $urandom_range(4) - 2);
        if ($urandom_range(1)) eta = -eta;
        phi = 16'(beh_pkg::PHI_EDGES[$urandom_range(beh_pkg::DEF_PHI_BINS)]
                  + $urandom_range(4) - 2);
        return event_request(pt, eta, phi, $urandom_range(3) != 0, $urandom_range(3) != 0);
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, edge values, pass flag mix and reads.
        send_request(event_request(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
        send_request(event_request(16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0));
        send_request(event_request(16'hFFFF, 16'h8000, 16'h8000, 1'b0, 1'b1));
        send_request(event_request(16'd320, 16'd10650, 16'd13108, 1'b0, 1'b0));
        send_request(event_request(16'd319, -16'sd10649, 16'd13107, 1'b1, 1'b1));
        send_request(event_request(16'd3200, 16'd1, -16'sd13107, 1'b1, 1'b1));
        send_request(event_request(16'd3199, -16'sd1, -16'sd13108, 1'b1, 1'b1));
        send_request(event_request(16'd3199, -16'sd1, -16'sd13108, 1'b0, 1'b1));
        send_request(read_request(5'd0, 5'd0, 4'd0));
        send_request(read_request(5'd31, 5'd31, 4'd15));
        send_request(read_request(5'd16, 5'd17, 4'd13));
        send_request(read_request(5'd17, 5'd18, 4'd14));
        send_request(read_request(5'd14, 5'd1, 4'd0));
        for (int n = 0; n < 1550; n++) begin
            if (n == 0) begin
                send_idle_pct = 28;
                recv_idle_pct = 60;
            end else if (n == 520) begin
                send_idle_pct = 60;
                recv_idle_pct = 28;
            end else if (n == 1040) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(random_request());
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d event records and %0d bin reads, %0d results compared.",
                 records, reads, results);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
